// ----- hdl/ffha_pkg.sv -----
package ffha_pkg;

    localparam int HEAP_BYTES  = 65536;
    localparam int ALIGN_BYTES = 8;
    localparam int MIN_BLOCK   = 2 * ALIGN_BYTES;
    localparam int TAG_W       = 32;
    localparam int TAG_DEPTH   = HEAP_BYTES / 4;
    localparam int TAG_AW      = $clog2(TAG_DEPTH);
    localparam int ADDR_W      = 36;
    localparam int BRK_W       = $clog2(HEAP_BYTES) + 1;
    localparam int CHUNK_W     = 17;
    localparam int REQ_W       = 20;
    localparam int ASIZE_W     = REQ_W + 1;
    localparam int OFF_W       = 16;
    localparam int FIRST_BP    = 8;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4096);

    localparam logic [1:0] FN_INIT  = 2'd0;
    localparam logic [1:0] FN_ALLOC = 2'd1;
    localparam logic [1:0] FN_FREE  = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_IGN = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [REQ_W-1:0] req_size;
        logic [OFF_W-1:0] block_addr;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] result_addr;
    } result_t;

endpackage

// ----- hdl/ffha_ram.sv -----
module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- hdl/first_fit_heap_allocator_top.sv -----
// One command at a time: busy is high while the sequencer works, done pulses in the
// first cycle with busy low and cannot be stalled. A zero request, a null free,
// command 3, or an alloc or free on an unset heap finish without busy going high.
// Init may fail if the chunk does not fit; free merges with its neighbours; allocate
// walks the blocks, grows the heap when none fits, then carves. At most one tag RAM access per cycle.
// Reset sets the break to 0 (heap unset) and the chunk size to 4096; tag RAM is kept.
module first_fit_heap_allocator_top
    import ffha_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cmd_t               cmd,
    output logic               done,
    output result_t            result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CHUNK_W-1:0] cfg_data
);

    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_INIT0  = 6'd1;
    localparam logic [5:0] S_INIT1  = 6'd2;
    localparam logic [5:0] S_INIT2  = 6'd3;
    localparam logic [5:0] S_INIT3  = 6'd4;
    localparam logic [5:0] S_FF_CHK = 6'd5;
    localparam logic [5:0] S_FF_USE = 6'd6;
    localparam logic [5:0] S_GR_CHK = 6'd7;
    localparam logic [5:0] S_GR_W0  = 6'd8;
    localparam logic [5:0] S_GR_W1  = 6'd9;
    localparam logic [5:0] S_GR_W2  = 6'd10;
    localparam logic [5:0] S_FR_RD  = 6'd11;
    localparam logic [5:0] S_FR_W0  = 6'd12;
    localparam logic [5:0] S_FR_W1  = 6'd13;
    localparam logic [5:0] S_M_R1   = 6'd14;
    localparam logic [5:0] S_M_R2   = 6'd15;
    localparam logic [5:0] S_M_R3   = 6'd16;
    localparam logic [5:0] S_M_R4   = 6'd17;
    localparam logic [5:0] S_M_R5   = 6'd18;
    localparam logic [5:0] S_M_R6   = 6'd19;
    localparam logic [5:0] S_C2W0   = 6'd20;
    localparam logic [5:0] S_C2W1   = 6'd21;
    localparam logic [5:0] S_C3W0   = 6'd22;
    localparam logic [5:0] S_C3W1   = 6'd23;
    localparam logic [5:0] S_C4W0   = 6'd24;
    localparam logic [5:0] S_C4W1   = 6'd25;
    localparam logic [5:0] S_CV_RD  = 6'd26;
    localparam logic [5:0] S_CV_USE = 6'd27;
    localparam logic [5:0] S_CV_S0  = 6'd28;
    localparam logic [5:0] S_CV_S1  = 6'd29;
    localparam logic [5:0] S_CV_S2  = 6'd30;
    localparam logic [5:0] S_CV_S3  = 6'd31;
    localparam logic [5:0] S_CV_N0  = 6'd32;
    localparam logic [5:0] S_CV_N1  = 6'd33;

    logic [5:0]         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [ADDR_W-1:0]  bp_reg, bp_next;
    logic [ADDR_W-1:0]  sz_reg, sz_next;
    logic [ADDR_W-1:0]  psz_reg, psz_next;
    logic [ADDR_W-1:0]  nsz_reg, nsz_next;
    logic [ADDR_W-1:0]  pb_reg, pb_next;
    logic [ADDR_W-1:0]  acc_reg, acc_next;
    logic               pa_reg, pa_next;
    logic               na_reg, na_next;
    logic [ASIZE_W-1:0] asize_reg, asize_next;
    logic [BRK_W-1:0]   brk_reg, brk_next;
    logic [CHUNK_W-1:0] chunk_reg;
    logic               rd_ok_reg;
    logic               done_reg;
    result_t            res_reg;

    logic               fin;
    logic [1:0]         fin_status;
    logic [OFF_W-1:0]   fin_addr;

    logic [ADDR_W-1:0]  m_addr;
    logic [ADDR_W-1:0]  m_wdata;
    logic               m_rd, m_wr, in_range;
    logic [TAG_W-1:0]   ram_rdata, tagv;
    logic [ADDR_W-1:0]  tsize;
    logic               talloc;

    logic [ADDR_W-1:0]  asize_x, chunk_x, brk_x, gsz_raw, gsz, ext_x;
    logic [ASIZE_W-1:0] asize_calc;

    assign in_range = (m_addr < ADDR_W'(HEAP_BYTES));
    assign tagv     = rd_ok_reg ? ram_rdata : '0;
    assign tsize    = ADDR_W'({tagv[TAG_W-1:3], 3'b000});
    assign talloc   = tagv[0];

    assign asize_x = ADDR_W'(asize_reg);
    assign chunk_x = ADDR_W'(chunk_reg);
    assign brk_x   = ADDR_W'(brk_reg);
    assign ext_x   = (asize_x > chunk_x) ? asize_x : chunk_x;
    assign gsz_raw = (acc_reg + ADDR_W'(4)) & ~ADDR_W'(7);
    assign gsz     = (gsz_raw == '0) ? ADDR_W'(8) : gsz_raw;

    assign asize_calc = (cmd.req_size <= REQ_W'(ALIGN_BYTES)) ? ASIZE_W'(MIN_BLOCK)
                      : ((ASIZE_W'(cmd.req_size) + ASIZE_W'(2 * ALIGN_BYTES - 1))
                         & ~ASIZE_W'(ALIGN_BYTES - 1));

    ffha_ram #(
        .WIDTH(TAG_W),
        .DEPTH(TAG_DEPTH)
    ) u_tag_ram (
        .clk  (clk),
        .en   ((m_rd | m_wr) & in_range),
        .we   (m_wr),
        .addr (m_addr[TAG_AW+1:2]),
        .wdata(m_wdata[TAG_W-1:0]),
        .rdata(ram_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        bp_next    = bp_reg;
        sz_next    = sz_reg;
        psz_next   = psz_reg;
        nsz_next   = nsz_reg;
        pb_next    = pb_reg;
        acc_next   = acc_reg;
        pa_next    = pa_reg;
        na_next    = na_reg;
        asize_next = asize_reg;
        brk_next   = brk_reg;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_addr   = '0;
        m_addr     = '0;
        m_wdata    = '0;
        m_rd       = 1'b0;
        m_wr       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = cmd.func;
                    unique case (cmd.func)
                        FN_INIT:
                        begin
                            state_next = S_INIT0;
                        end
                        FN_ALLOC:
                        begin
                            if (cmd.req_size == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_IGN;
                            end
                            else if (brk_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_OOM;
                            end
                            else
                            begin
                                asize_next = asize_calc;
                                bp_next    = ADDR_W'(FIRST_BP);
                                state_next = S_FF_CHK;
                            end
                        end
                        FN_FREE:
                        begin
                            if (cmd.block_addr == '0 || brk_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_IGN;
                            end
                            else
                            begin
                                bp_next    = ADDR_W'(cmd.block_addr);
                                state_next = S_FR_RD;
                            end
                        end
                        default:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_IGN;
                        end
                    endcase
                end
            end
            S_INIT0:
            begin
                m_wr       = 1'b1;
                m_addr     = ADDR_W'(0);
                m_wdata    = '0;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                m_wr       = 1'b1;
                m_addr     = ADDR_W'(4);
                m_wdata    = ADDR_W'(9);
                state_next = S_INIT2;
            end
            S_INIT2:
            begin
                m_wr       = 1'b1;
                m_addr     = ADDR_W'(8);
                m_wdata    = ADDR_W'(9);
                state_next = S_INIT3;
            end
            S_INIT3:
            begin
                m_wr       = 1'b1;
                m_addr     = ADDR_W'(12);
                m_wdata    = ADDR_W'(1);
                brk_next   = BRK_W'(16);
                acc_next   = chunk_x;
                state_next = S_GR_CHK;
            end
            S_FF_CHK:
            begin
                if (bp_reg > brk_x)
                begin
                    acc_next   = ext_x;
                    state_next = S_GR_CHK;
                end
                else
                begin
                    m_rd       = 1'b1;
                    m_addr     = bp_reg - ADDR_W'(4);
                    state_next = S_FF_USE;
                end
            end
            S_FF_USE:
            begin
                if (tsize == '0)
                begin
                    acc_next   = ext_x;
                    state_next = S_GR_CHK;
                end
                else if (!talloc && asize_x <= tsize)
                begin
                    state_next = S_CV_RD;
                end
                else
                begin
                    bp_next    = bp_reg + tsize;
                    state_next = S_FF_CHK;
                end
            end
            S_GR_CHK:
            begin
                if (brk_x + gsz > ADDR_W'(HEAP_BYTES))
                begin
                    fin        = 1'b1;
                    fin_status = ST_OOM;
                    state_next = S_IDLE;
                end
                else
                begin
                    bp_next    = brk_x;
                    sz_next    = gsz;
                    state_next = S_GR_W0;
                end
            end
            S_GR_W0:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg - ADDR_W'(4);
                m_wdata    = sz_reg;
                state_next = S_GR_W1;
            end
            S_GR_W1:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg + sz_reg - ADDR_W'(8);
                m_wdata    = sz_reg;
                state_next = S_GR_W2;
            end
            S_GR_W2:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg + sz_reg - ADDR_W'(4);
                m_wdata    = ADDR_W'(1);
                brk_next   = BRK_W'(bp_reg + sz_reg);
                state_next = S_M_R1;
            end
            S_FR_RD:
            begin
                m_rd       = 1'b1;
                m_addr     = bp_reg - ADDR_W'(4);
                state_next = S_FR_W0;
            end
            S_FR_W0:
            begin
                sz_next    = tsize;
                m_wr       = 1'b1;
                m_addr     = bp_reg - ADDR_W'(4);
                m_wdata    = tsize;
                state_next = S_FR_W1;
            end
            S_FR_W1:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg + sz_reg - ADDR_W'(8);
                m_wdata    = sz_reg;
                state_next = S_M_R1;
            end
            // merge: read own header, previous footer, next header
            S_M_R1:
            begin
                m_rd       = 1'b1;
                m_addr     = bp_reg - ADDR_W'(4);
                state_next = S_M_R2;
            end
            S_M_R2:
            begin
                sz_next    = tsize;
                m_rd       = 1'b1;
                m_addr     = bp_reg - ADDR_W'(8);
                state_next = S_M_R3;
            end
            S_M_R3:
            begin
                psz_next   = tsize;
                pa_next    = talloc;
                m_rd       = 1'b1;
                m_addr     = bp_reg + sz_reg - ADDR_W'(4);
                state_next = S_M_R4;
            end
            S_M_R4:
            begin
                nsz_next = tsize;
                na_next  = talloc;
                if (pa_reg && talloc)
                begin
                    if (op_reg == FN_ALLOC)
                    begin
                        state_next = S_CV_RD;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (pa_reg)
                begin
                    sz_next    = sz_reg + tsize;
                    state_next = S_C2W0;
                end
                else
                begin
                    pb_next    = bp_reg - psz_reg;
                    m_rd       = 1'b1;
                    m_addr     = bp_reg - psz_reg - ADDR_W'(4);
                    state_next = S_M_R5;
                end
            end
            S_M_R5:
            begin
                if (na_reg)
                begin
                    acc_next   = sz_reg + tsize;
                    state_next = S_C3W0;
                end
                else
                begin
                    psz_next   = tsize;
                    m_rd       = 1'b1;
                    m_addr     = bp_reg + sz_reg + nsz_reg - ADDR_W'(8);
                    state_next = S_M_R6;
                end
            end
            S_M_R6:
            begin
                acc_next   = sz_reg + tsize + psz_reg;
                state_next = S_C4W0;
            end
            S_C2W0:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg - ADDR_W'(4);
                m_wdata    = sz_reg;
                state_next = S_C2W1;
            end
            S_C3W0:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg + sz_reg - ADDR_W'(8);
                m_wdata    = acc_reg;
                state_next = S_C3W1;
            end
            S_C4W0:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg + sz_reg + nsz_reg - ADDR_W'(8);
                m_wdata    = acc_reg;
                state_next = S_C4W1;
            end
            S_C2W1, S_C3W1, S_C4W1:
            begin
                m_wr = 1'b1;
                if (state_reg == S_C2W1)
                begin
                    m_addr  = bp_reg + sz_reg - ADDR_W'(8);
                    m_wdata = sz_reg;
                end
                else
                begin
                    m_addr  = pb_reg - ADDR_W'(4);
                    m_wdata = acc_reg;
                    bp_next = pb_reg;
                end
                if (op_reg == FN_ALLOC)
                begin
                    state_next = S_CV_RD;
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CV_RD:
            begin
                m_rd       = 1'b1;
                m_addr     = bp_reg - ADDR_W'(4);
                state_next = S_CV_USE;
            end
            S_CV_USE:
            begin
                acc_next = tsize;
                if (tsize >= asize_x + ADDR_W'(MIN_BLOCK))
                begin
                    state_next = S_CV_S0;
                end
                else
                begin
                    state_next = S_CV_N0;
                end
            end
            S_CV_S0:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg - ADDR_W'(4);
                m_wdata    = asize_x | ADDR_W'(1);
                state_next = S_CV_S1;
            end
            S_CV_S1:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg + asize_x - ADDR_W'(8);
                m_wdata    = asize_x | ADDR_W'(1);
                state_next = S_CV_S2;
            end
            S_CV_S2:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg + asize_x - ADDR_W'(4);
                m_wdata    = acc_reg - asize_x;
                state_next = S_CV_S3;
            end
            S_CV_S3:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg + acc_reg - ADDR_W'(8);
                m_wdata    = acc_reg - asize_x;
                fin        = 1'b1;
                fin_addr   = bp_reg[OFF_W-1:0];
                state_next = S_IDLE;
            end
            S_CV_N0:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg - ADDR_W'(4);
                m_wdata    = acc_reg | ADDR_W'(1);
                state_next = S_CV_N1;
            end
            S_CV_N1:
            begin
                m_wr       = 1'b1;
                m_addr     = bp_reg + acc_reg - ADDR_W'(8);
                m_wdata    = acc_reg | ADDR_W'(1);
                fin        = 1'b1;
                fin_addr   = bp_reg[OFF_W-1:0];
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            brk_reg   <= '0;
            chunk_reg <= CHUNK_RESET;
            done_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
            op_reg    <= FN_INIT;
        end
        else
        begin
            state_reg <= state_next;
            brk_reg   <= brk_next;
            done_reg  <= fin;
            rd_ok_reg <= in_range;
            op_reg    <= op_next;
            if (cfg_valid && cfg_ready)
            begin
                chunk_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bp_reg    <= bp_next;
        sz_reg    <= sz_next;
        psz_reg   <= psz_next;
        nsz_reg   <= nsz_next;
        pb_reg    <= pb_next;
        acc_reg   <= acc_next;
        pa_reg    <= pa_next;
        na_reg    <= na_next;
        asize_reg <= asize_next;
        if (fin)
        begin
            res_reg.status      <= fin_status;
            res_reg.result_addr <= fin_addr;
        end
    end

endmodule
